/* hw/rtl/gdfs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS walker package
// Shared types, codes and constants for the walker controller and datapath.
// ---------------------------------------------------------------------------
package gdfs_pkg;

    localparam int GRID_SIZE_DEF = 6;

    localparam int COORD_W   = 3;
    localparam int DIR_W     = 3;
    localparam int TURN_W    = 2;
    localparam int NEXT_W    = 3;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MARK_OPEN = 2'd0,
        MARK_WALL = 2'd1,
        MARK_PATH = 2'd2,
        MARK_DEAD = 2'd3
    } t_mark;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd4;

    localparam logic [TURN_W-1:0] TURN_FWD   = 2'd0;
    localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd1;
    localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    localparam logic [NEXT_W-1:0] NEIGHBOR_CNT = 3'd4;

    localparam logic [COORD_W-1:0] START_ROW_RST = 3'd5;
    localparam logic [COORD_W-1:0] START_COL_RST = 3'd5;
    localparam logic [COORD_W-1:0] GOAL_ROW_RST  = 3'd0;
    localparam logic [COORD_W-1:0] GOAL_COL_RST  = 3'd0;

    typedef struct packed {
        logic                 action;
        logic [COORD_W-1:0]   cell_row;
        logic [COORD_W-1:0]   cell_col;
        logic                 cell_wall;
    } t_item_word;

    typedef struct packed {
        logic [COORD_W-1:0]   step_row;
        logic [COORD_W-1:0]   step_col;
        logic [DIR_W-1:0]     move_dir;
        logic [TURN_W-1:0]    turn_cmd;
        logic                 goal_found;
        logic                 last;
    } t_res_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [COORD_W-1:0]   reg_value;
    } t_cfg_word;

    typedef struct packed {
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [NEXT_W-1:0]    next;
    } t_stk_entry;

    typedef struct packed {
        logic load_wr;
        logic run_init;
        logic mark_rd;
        logic enter;
        logic sel_next;
        logic dead_pop;
        logic pop_load;
        logic emit_final;
        logic final_found;
    } t_cmd;

    typedef struct packed {
        logic cand_out;
        logic cand_goal;
        logic cand_free;
        logic top_done;
        logic depth_zero;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/gdfs_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS walker channels
// Valid/ready channels for input items, results and register writes.
// ---------------------------------------------------------------------------
interface gdfs_item_if;
    logic                 valid;
    logic                 ready;
    gdfs_pkg::t_item_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdfs_res_if;
    logic                valid;
    logic                ready;
    gdfs_pkg::t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdfs_cfg_if;
    logic                valid;
    logic                ready;
    gdfs_pkg::t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/gdfs_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS walker controller
// Sequences cell loads, neighbor tries, backtracking and the final word.
// ---------------------------------------------------------------------------
module gdfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  logic              i_item_action,
    output logic              o_item_ready,
    input  gdfs_pkg::t_status i_status,
    output gdfs_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_TRY,
        S_CHECK,
        S_POP,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_found;
    logic   n_found;

    assign o_item_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item_action == gdfs_pkg::ACT_RUN) begin
                        o_cmd.run_init = 1'b1;
                        n_found        = 1'b0;
                        n_state        = S_TRY;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_TRY: begin
                if (i_status.cand_out) begin
                    n_state = S_SEL;
                end else if (i_status.cand_goal) begin
                    n_found = 1'b1;
                    n_state = S_FINAL;
                end else begin
                    o_cmd.mark_rd = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.cand_free) begin
                    n_state = S_SEL;
                end else if (i_status.out_free) begin
                    o_cmd.enter = 1'b1;
                    n_state     = S_SEL;
                end
            end
            S_SEL: begin
                if (i_status.depth_zero) begin
                    n_state = S_FINAL;
                end else if (i_status.top_done) begin
                    o_cmd.dead_pop = 1'b1;
                    n_state        = S_POP;
                end else begin
                    o_cmd.sel_next = 1'b1;
                    n_state        = S_TRY;
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_SEL;
            end
            S_FINAL: begin
                o_cmd.final_found = r_found;
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

endmodule

/* hw/rtl/gdfs_dpath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS walker datapath
// Holds the cell mark memory, the search stack, registers and result word.
// ---------------------------------------------------------------------------
module gdfs_dpath #(
    parameter int GRID_SIZE = gdfs_pkg::GRID_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gdfs_pkg::t_cmd       i_cmd,
    output gdfs_pkg::t_status    o_status,
    input  gdfs_pkg::t_item_word i_item_data,
    gdfs_cfg_if.sink             i_cfg,
    gdfs_res_if.source           o_res
);

    localparam int CELLS   = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W   = $clog2(CELLS);
    localparam int DEPTH_W = $clog2(CELLS + 1);
    localparam int CW      = gdfs_pkg::COORD_W;

    localparam logic [CW:0]        GRID_LIM  = (CW + 1)'(GRID_SIZE);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(CELLS);

    function automatic logic [IDX_W-1:0] cell_index(logic [CW-1:0] row, logic [CW-1:0] col);
        return IDX_W'(int'(row) * GRID_SIZE + int'(col));
    endfunction

    logic [CW-1:0] r_start_row;
    logic [CW-1:0] r_start_col;
    logic [CW-1:0] r_goal_row;
    logic [CW-1:0] r_goal_col;

    logic [CW:0]                    r_cand_row;
    logic [CW:0]                    r_cand_col;
    logic [gdfs_pkg::DIR_W-1:0]     r_cand_dir;
    gdfs_pkg::t_stk_entry           r_top;
    logic [DEPTH_W-1:0]             r_depth;
    logic [gdfs_pkg::DIR_W-1:0]     r_heading;

    gdfs_pkg::t_mark                mark_mem [CELLS];
    logic [CELLS-1:0]               r_mark_vld;
    gdfs_pkg::t_mark                r_mark_q;
    logic                           r_mark_q_vld;
    gdfs_pkg::t_stk_entry           stk_mem [CELLS];
    gdfs_pkg::t_stk_entry           r_stk_q;

    logic                           r_out_valid;
    gdfs_pkg::t_res_word            r_out;

    logic                           mark_we;
    logic [IDX_W-1:0]               mark_waddr;
    gdfs_pkg::t_mark                mark_wdata;
    logic [IDX_W-1:0]               cand_idx;
    logic [IDX_W-1:0]               top_idx;
    gdfs_pkg::t_mark                cand_mark;
    logic [DEPTH_W-1:0]             depth_m1;
    logic [DEPTH_W-1:0]             depth_m2;
    logic                           load_in_grid;
    logic [gdfs_pkg::TURN_W-1:0]    turn;
    logic [CW:0]                    n_cand_row;
    logic [CW:0]                    n_cand_col;
    logic [gdfs_pkg::DIR_W-1:0]     n_cand_dir;

    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign cand_idx     = cell_index(r_cand_row[CW-1:0], r_cand_col[CW-1:0]);
    assign top_idx      = cell_index(r_top.row, r_top.col);
    assign cand_mark    = r_mark_q_vld ? r_mark_q : gdfs_pkg::MARK_OPEN;
    assign depth_m1     = r_depth - DEPTH_W'(1);
    assign depth_m2     = r_depth - DEPTH_W'(2);
    assign load_in_grid = ({1'b0, i_item_data.cell_row} < GRID_LIM) &&
                          ({1'b0, i_item_data.cell_col} < GRID_LIM);

    always_comb begin
        if (r_cand_dir < r_heading) begin
            turn = gdfs_pkg::TURN_RIGHT;
        end else if (r_cand_dir > r_heading) begin
            turn = gdfs_pkg::TURN_LEFT;
        end else begin
            turn = gdfs_pkg::TURN_FWD;
        end
    end

    always_comb begin
        n_cand_dir = r_top.next + gdfs_pkg::DIR_W'(1);
        n_cand_row = {1'b0, r_top.row};
        n_cand_col = {1'b0, r_top.col};
        case (n_cand_dir)
            gdfs_pkg::DIR_UP:    n_cand_row = {1'b0, r_top.row} - (CW + 1)'(1);
            gdfs_pkg::DIR_RIGHT: n_cand_col = {1'b0, r_top.col} + (CW + 1)'(1);
            gdfs_pkg::DIR_DOWN:  n_cand_row = {1'b0, r_top.row} + (CW + 1)'(1);
            gdfs_pkg::DIR_LEFT:  n_cand_col = {1'b0, r_top.col} - (CW + 1)'(1);
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.cand_out   = (r_cand_row >= GRID_LIM) || (r_cand_col >= GRID_LIM);
        o_status.cand_goal  = (r_cand_row == {1'b0, r_goal_row}) &&
                              (r_cand_col == {1'b0, r_goal_col});
        o_status.cand_free  = (cand_mark == gdfs_pkg::MARK_OPEN) && (r_depth < DEPTH_MAX);
        o_status.top_done   = (r_top.next >= gdfs_pkg::NEIGHBOR_CNT);
        o_status.depth_zero = (r_depth == '0);
        o_status.out_free   = !r_out_valid || o_res.ready;
    end

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = cand_idx;
        mark_wdata = gdfs_pkg::MARK_PATH;
        if (i_cmd.load_wr && load_in_grid) begin
            mark_we    = 1'b1;
            mark_waddr = cell_index(i_item_data.cell_row, i_item_data.cell_col);
            mark_wdata = i_item_data.cell_wall ? gdfs_pkg::MARK_WALL : gdfs_pkg::MARK_OPEN;
        end else if (i_cmd.enter) begin
            mark_we    = 1'b1;
        end else if (i_cmd.dead_pop) begin
            mark_we    = 1'b1;
            mark_waddr = top_idx;
            mark_wdata = gdfs_pkg::MARK_DEAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (i_cmd.mark_rd) begin
            r_mark_q <= mark_mem[cand_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enter && (r_depth != '0)) begin
            stk_mem[depth_m1[IDX_W-1:0]] <= r_top;
        end
        if (i_cmd.dead_pop && (r_depth >= DEPTH_W'(2))) begin
            r_stk_q <= stk_mem[depth_m2[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_vld   <= '0;
            r_mark_q_vld <= 1'b0;
        end else begin
            if (mark_we) begin
                r_mark_vld[mark_waddr] <= 1'b1;
            end
            if (i_cmd.mark_rd) begin
                r_mark_q_vld <= r_mark_vld[cand_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= gdfs_pkg::START_ROW_RST;
            r_start_col <= gdfs_pkg::START_COL_RST;
            r_goal_row  <= gdfs_pkg::GOAL_ROW_RST;
            r_goal_col  <= gdfs_pkg::GOAL_COL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                gdfs_pkg::REG_START_ROW: r_start_row <= i_cfg.data.reg_value;
                gdfs_pkg::REG_START_COL: r_start_col <= i_cfg.data.reg_value;
                gdfs_pkg::REG_GOAL_ROW:  r_goal_row  <= i_cfg.data.reg_value;
                gdfs_pkg::REG_GOAL_COL:  r_goal_col  <= i_cfg.data.reg_value;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_cand_row <= {1'b0, r_start_row};
            r_cand_col <= {1'b0, r_start_col};
            r_cand_dir <= gdfs_pkg::DIR_UP;
        end else if (i_cmd.sel_next) begin
            r_cand_row <= n_cand_row;
            r_cand_col <= n_cand_col;
            r_cand_dir <= n_cand_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enter) begin
            r_top.row  <= r_cand_row[CW-1:0];
            r_top.col  <= r_cand_col[CW-1:0];
            r_top.next <= '0;
        end else if (i_cmd.sel_next) begin
            r_top.next <= r_top.next + gdfs_pkg::NEXT_W'(1);
        end else if (i_cmd.pop_load) begin
            r_top <= r_stk_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_heading   <= gdfs_pkg::DIR_UP;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.run_init || i_cmd.emit_final) begin
                r_depth <= '0;
            end else if (i_cmd.enter) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.dead_pop) begin
                r_depth <= depth_m1;
            end
            if (i_cmd.enter) begin
                r_heading <= r_cand_dir;
            end
            if (i_cmd.enter || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enter) begin
            r_out.step_row   <= r_cand_row[CW-1:0];
            r_out.step_col   <= r_cand_col[CW-1:0];
            r_out.move_dir   <= r_cand_dir;
            r_out.turn_cmd   <= turn;
            r_out.goal_found <= 1'b0;
            r_out.last       <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out.step_row   <= '0;
            r_out.step_col   <= '0;
            r_out.move_dir   <= gdfs_pkg::DIR_NONE;
            r_out.turn_cmd   <= gdfs_pkg::TURN_FWD;
            r_out.goal_found <= i_cmd.final_found;
            r_out.last       <= 1'b1;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("search stack depth exceeds the cell count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.enter || i_cmd.emit_final) |-> o_status.out_free)
        else $error("result word overwritten before it was taken");

    a_enter_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enter |-> (!o_status.cand_out && !o_status.cand_goal && o_status.cand_free))
        else $error("entered a blocked, outside or goal cell");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dead_pop |-> !o_status.depth_zero)
        else $error("backtrack on an empty stack");

    a_path_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enter |=> (r_depth == $past(r_depth) + DEPTH_W'(1)) && r_out_valid)
        else $error("entered cell did not push and emit a step");

endmodule

/* hw/rtl/grid_maze_dfs_path_walker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS path walker
// Depth-first search over a loadable grid of open and wall cells.
// ---------------------------------------------------------------------------
// A load word writes one cell as open or wall, clearing its search marks; a
// load outside the grid is dropped. A run word searches depth first from the
// start to the goal register, trying up, right, down and left, and returns one
// step word per entered cell followed by a final word. Each neighbor try waits
// on the registered read of the single mark memory and each backtrack on the
// registered read of the stack memory; an entered cell or the final word also
// waits until the result side has taken the last result word. Only one word is
// in work at a time. Marks persist between runs until cells are reloaded.
module grid_maze_dfs_path_walker #(
    parameter int GRID_SIZE = gdfs_pkg::GRID_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdfs_item_if.sink   i_item,
    gdfs_res_if.source  o_res,
    gdfs_cfg_if.sink    i_cfg
);

    gdfs_pkg::t_cmd    cmd;
    gdfs_pkg::t_status status;
    logic              item_ready;

    assign i_item.ready = item_ready;

    gdfs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_item.valid),
        .i_item_action (i_item.data.action),
        .o_item_ready  (item_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    gdfs_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item_data (i_item.data),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid maze DFS path walker testbench
// Loads mazes cell by cell and launches searches under changing start and
// goal settings, with random gaps on both channels and one long result
// stall. A behavioral depth-first walker predicts every step and final word,
// and each returned word is compared field by field against it.
// ---------------------------------------------------------------------------
module tb;

    localparam int GRID          = gdfs_pkg::GRID_SIZE_DEF;
    localparam int CELLS         = GRID * GRID;
    localparam int ITEM_TARGET   = 430;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    localparam int PROBE_FOUND   = 0;
    localparam int PROBE_BLOCKED = 1;
    localparam int PROBE_ENTERED = 2;

    logic i_clk;
    logic i_rst_n;

    gdfs_item_if item_bus ();
    gdfs_res_if  res_bus ();
    gdfs_cfg_if  cfg_bus ();

    grid_maze_dfs_path_walker #(
        .GRID_SIZE(GRID)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item_bus),
        .o_res  (res_bus),
        .i_cfg  (cfg_bus)
    );

    gdfs_pkg::t_item_word pending_words [$];
    gdfs_pkg::t_res_word  expected_steps [$];

    gdfs_pkg::t_mark              maze_marks [GRID][GRID];
    int                           trail_row [CELLS];
    int                           trail_col [CELLS];
    int                           trail_next [CELLS];
    int                           trail_depth;
    logic [gdfs_pkg::DIR_W-1:0]   heading;
    logic [gdfs_pkg::COORD_W-1:0] start_row;
    logic [gdfs_pkg::COORD_W-1:0] start_col;
    logic [gdfs_pkg::COORD_W-1:0] goal_row;
    logic [gdfs_pkg::COORD_W-1:0] goal_col;

    int   mismatches;
    int   items_queued;
    int   item_gap;
    int   item_gap_max;
    int   res_pause;
    int   res_gap_max;
    logic res_hold;
    logic press_go;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    function automatic int probe_cell(int r, int c, logic [gdfs_pkg::DIR_W-1:0] dir);
        gdfs_pkg::t_res_word s;
        if (r < 0 || c < 0 || r >= GRID || c >= GRID) begin
            return PROBE_BLOCKED;
        end
        if (r == int'(goal_row) && c == int'(goal_col)) begin
            return PROBE_FOUND;
        end
        if (maze_marks[r][c] != gdfs_pkg::MARK_OPEN || trail_depth >= CELLS) begin
            return PROBE_BLOCKED;
        end
        maze_marks[r][c] = gdfs_pkg::MARK_PATH;
        s = '0;
        s.step_row = gdfs_pkg::COORD_W'(r);
        s.step_col = gdfs_pkg::COORD_W'(c);
        s.move_dir = dir;
        if (dir < heading) begin
            s.turn_cmd = gdfs_pkg::TURN_RIGHT;
        end else if (dir > heading) begin
            s.turn_cmd = gdfs_pkg::TURN_LEFT;
        end else begin
            s.turn_cmd = gdfs_pkg::TURN_FWD;
        end
        heading = dir;
        expected_steps.push_back(s);
        trail_row[trail_depth] = r;
        trail_col[trail_depth] = c;
        trail_next[trail_depth] = 0;
        trail_depth++;
        return PROBE_ENTERED;
    endfunction

    function automatic void predict_search();
        logic [gdfs_pkg::DIR_W-1:0] dirs [4];
        int                         dr [4];
        int                         dc [4];
        int                         top;
        int                         k;
        logic                       found;
        gdfs_pkg::t_res_word        fin;
        dirs = '{gdfs_pkg::DIR_UP, gdfs_pkg::DIR_RIGHT, gdfs_pkg::DIR_DOWN, gdfs_pkg::DIR_LEFT};
        dr = '{-1, 0, 1, 0};
        dc = '{0, 1, 0, -1};
        trail_depth = 0;
        found = (probe_cell(int'(start_row), int'(start_col), gdfs_pkg::DIR_UP)
                 == PROBE_FOUND);
        while (!found && trail_depth > 0) begin
            top = trail_depth - 1;
            k = trail_next[top];
            if (k >= gdfs_pkg::NEIGHBOR_CNT) begin
                maze_marks[trail_row[top]][trail_col[top]] = gdfs_pkg::MARK_DEAD;
                trail_depth--;
            end else begin
                trail_next[top] = k + 1;
                if (probe_cell(trail_row[top] + dr[k], trail_col[top] + dc[k], dirs[k])
                        == PROBE_FOUND) begin
                    found = 1'b1;
                end
            end
        end
        trail_depth = 0;
        fin = '0;
        fin.move_dir = gdfs_pkg::DIR_NONE;
        fin.goal_found = found;
        fin.last = 1'b1;
        expected_steps.push_back(fin);
    endfunction

    function automatic void predict_walk(gdfs_pkg::t_item_word w);
        if (w.action == gdfs_pkg::ACT_LOAD) begin
            if (w.cell_row < GRID && w.cell_col < GRID) begin
                maze_marks[w.cell_row][w.cell_col] =
                    w.cell_wall ? gdfs_pkg::MARK_WALL : gdfs_pkg::MARK_OPEN;
            end
        end else begin
            predict_search();
        end
    endfunction

    task automatic check_result(gdfs_pkg::t_res_word got);
        gdfs_pkg::t_res_word want;
        if (expected_steps.size() == 0) begin
            report_mismatch("unexpected result word", got, '0);
            return;
        end
        want = expected_steps.pop_front();
        if (got.step_row !== want.step_row) begin
            report_mismatch("step_row", got.step_row, want.step_row);
        end
        if (got.step_col !== want.step_col) begin
            report_mismatch("step_col", got.step_col, want.step_col);
        end
        if (got.move_dir !== want.move_dir) begin
            report_mismatch("move_dir", got.move_dir, want.move_dir);
        end
        if (got.turn_cmd !== want.turn_cmd) begin
            report_mismatch("turn_cmd", got.turn_cmd, want.turn_cmd);
        end
        if (got.goal_found !== want.goal_found) begin
            report_mismatch("goal_found", got.goal_found, want.goal_found);
        end
        if (got.last !== want.last) begin
            report_mismatch("last", got.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin : item_driver
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            item_gap <= 0;
        end else if (!item_bus.valid || item_bus.ready) begin
            if (item_gap != 0) begin
                item_bus.valid <= 1'b0;
                item_gap <= item_gap - 1;
            end else if (pending_words.size() != 0) begin
                item_bus.valid <= 1'b1;
                item_bus.data <= pending_words.pop_front();
                item_gap <= $urandom_range(0, item_gap_max);
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        int pause;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            res_pause <= 0;
        end else begin
            pause = res_pause;
            if (res_bus.valid && res_bus.ready) begin
                check_result(res_bus.data);
                pause = $urandom_range(0, res_gap_max);
            end else if (pause != 0 && !res_hold) begin
                pause--;
            end
            if (item_bus.valid && item_bus.ready) begin
                predict_walk(item_bus.data);
            end
            res_pause <= pause;
            res_bus.ready <= !res_hold && pause == 0;
        end
    end

    // The result side goes deaf for a long stretch so the walker backs up
    // and refuses new input words.
    initial begin : long_hold
        res_hold = 1'b0;
        @(posedge press_go);
        @(posedge i_clk);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        res_hold <= 1'b0;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_bus.valid && item_bus.ready)
                    || (res_bus.valid && res_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void queue_word(logic act, int r, int c, logic wall);
        gdfs_pkg::t_item_word w;
        w.action = act;
        w.cell_row = gdfs_pkg::COORD_W'(r);
        w.cell_col = gdfs_pkg::COORD_W'(c);
        w.cell_wall = wall;
        pending_words.push_back(w);
        if (act == gdfs_pkg::ACT_RUN || (r < GRID && c < GRID)) begin
            items_queued++;
        end
    endfunction

    function automatic void queue_run();
        queue_word(gdfs_pkg::ACT_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                   1'($urandom_range(0, 1)));
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(0, 4) == 0) begin
            return $urandom_range(0, 7);
        end
        return $urandom_range(0, GRID - 1);
    endfunction

    task automatic write_reg(logic [gdfs_pkg::CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= {idx, gdfs_pkg::COORD_W'(value)};
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            gdfs_pkg::REG_START_ROW: start_row = gdfs_pkg::COORD_W'(value);
            gdfs_pkg::REG_START_COL: start_col = gdfs_pkg::COORD_W'(value);
            gdfs_pkg::REG_GOAL_ROW:  goal_row = gdfs_pkg::COORD_W'(value);
            default:                 goal_col = gdfs_pkg::COORD_W'(value);
        endcase
    endtask

    task automatic set_route(int sr, int sc, int gr, int gc);
        write_reg(gdfs_pkg::REG_START_ROW, sr);
        write_reg(gdfs_pkg::REG_START_COL, sc);
        write_reg(gdfs_pkg::REG_GOAL_ROW, gr);
        write_reg(gdfs_pkg::REG_GOAL_COL, gc);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || item_bus.valid || expected_steps.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int chunk;
        int kind;
        int density;
        int n;
        logic wall;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        item_bus.valid = 1'b0;
        item_bus.data = '0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        press_go = 1'b0;
        mismatches = 0;
        items_queued = 0;
        item_gap_max = 0;
        res_gap_max = 0;
        trail_depth = 0;
        heading = gdfs_pkg::DIR_UP;
        start_row = gdfs_pkg::START_ROW_RST;
        start_col = gdfs_pkg::START_COL_RST;
        goal_row = gdfs_pkg::GOAL_ROW_RST;
        goal_col = gdfs_pkg::GOAL_COL_RST;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                maze_marks[r][c] = gdfs_pkg::MARK_OPEN;
            end
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty grid under the reset route, then a rerun whose start cell is
        // still marked, then loads outside the grid and a wall on the goal cell.
        queue_run();
        queue_run();
        queue_word(gdfs_pkg::ACT_LOAD, 7, 7, 1'b1);
        queue_word(gdfs_pkg::ACT_LOAD, 6, 0, 1'b1);
        queue_word(gdfs_pkg::ACT_LOAD, 0, 6, 1'b0);
        queue_word(gdfs_pkg::ACT_LOAD, 5, 5, 1'b0);
        queue_word(gdfs_pkg::ACT_LOAD, 0, 0, 1'b1);
        queue_run();
        wait_idle();
        set_route(0, 0, 0, 0);
        queue_run();
        wait_idle();
        set_route(7, 7, GRID - 1, GRID - 1);
        queue_run();
        wait_idle();
        set_route(0, 0, 6, 7);
        queue_word(gdfs_pkg::ACT_LOAD, 0, 0, 1'b0);
        queue_word(gdfs_pkg::ACT_LOAD, 1, 0, 1'b0);
        queue_word(gdfs_pkg::ACT_LOAD, 0, 1, 1'b0);
        queue_run();
        wait_idle();

        chunk = 0;
        while (items_queued < ITEM_TARGET) begin
            set_route(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            item_gap_max = $urandom_range(0, 1) ? 3 : 0;
            res_gap_max = $urandom_range(0, 1) ? 3 : 0;
            kind = $urandom_range(0, 9);
            if (chunk == 2) begin
                kind = 0;
                item_gap_max = 0;
            end
            if (kind < 6) begin
                density = $urandom_range(0, 45);
                for (int r = 0; r < GRID; r++) begin
                    for (int c = 0; c < GRID; c++) begin
                        wall = $urandom_range(0, 99) < density;
                        if (r == int'(start_row) && c == int'(start_col)) begin
                            wall = 1'b0;
                        end
                        queue_word(gdfs_pkg::ACT_LOAD, r, c, wall);
                    end
                end
                queue_run();
                if ($urandom_range(0, 1)) begin
                    queue_run();
                end
            end else if (kind < 9) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    queue_word(gdfs_pkg::ACT_LOAD, $urandom_range(0, 7),
                               $urandom_range(0, 7), 1'($urandom_range(0, 1)));
                end
                queue_run();
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                               $urandom_range(0, 7), 1'($urandom_range(0, 1)));
                end
            end
            if (chunk == 2) begin
                queue_run();
                press_go = 1'b1;
            end
            chunk++;
            wait_idle();
        end

        if (mismatches == 0 && expected_steps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/gdfs_pkg.sv
hw/rtl/gdfs_if.sv
hw/rtl/gdfs_ctrl.sv
hw/rtl/gdfs_dpath.sv
hw/rtl/grid_maze_dfs_path_walker.sv
tb/tb.sv
